>>> design/bctc_pkg.sv
`timescale 1ns / 1ps
package bctc_pkg;

	localparam int NUM_SLOTS = 256;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int BLK_W     = 63;

	// item kinds
	localparam logic [2:0] K_REQ    = 3'd0;
	localparam logic [2:0] K_DIRTY  = 3'd1;
	localparam logic [2:0] K_LOCK   = 3'd2;
	localparam logic [2:0] K_UNLOCK = 3'd3;
	localparam logic [2:0] K_FLUSH  = 3'd4;

	// result status codes
	localparam logic [2:0] ST_HIT    = 3'd0;
	localparam logic [2:0] ST_LOAD   = 3'd1;
	localparam logic [2:0] ST_APPEND = 3'd2;
	localparam logic [2:0] ST_LOCKED = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_HRD, S_HCMP, S_ALLOC, S_VSCAN, S_WBRD, S_WB, S_OPRD, S_OPDO
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_hit;
		logic step;
		logic alloc;
		logic vstep;
		logic rd_slot;
		logic commit;
		logic all_locked;
		logic hit;
		logic op_rd;
		logic op_do;
	} cmd_t;

	typedef struct packed {
		logic start_req;
		logic fill_zero;
		logic tag_match;
		logic scan_last;
		logic fill_full;
		logic vlocked;
		logic vlast;
	} stat_t;

endpackage

>>> design/block_cache_tag_controller.sv
`timescale 1ns / 1ps
// channel | signals                                                   | transaction
// item    | start, busy, kind, block_number, file_block_count, slot_index | start && !busy
// result  | done, status, slot_index_out, writeback_valid, writeback_block | done (one cycle)
// config  | cfg_valid, cfg_ready, cfg_data (read_only)                | cfg_valid && cfg_ready
// Request: a tag memory read then a compare for each filled slot compared; a miss
// adds allocation, a victim search over up to NUM_SLOTS slots when full, writeback
// read and commit. A hit takes only read/compare pairs. Slot operations: read then apply.
// Reset clears fill count, pointer, dirty and lock bits; tags need no clearing.
// The receiver cannot stall; results are strobed for one cycle.
module block_cache_tag_controller (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [2:0]                 kind,
	input  logic [bctc_pkg::BLK_W-1:0] block_number,
	input  logic [bctc_pkg::BLK_W-1:0] file_block_count,
	input  logic [7:0]                 slot_index,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data,
	output logic                       done,
	output logic [2:0]                 status,
	output logic [7:0]                 slot_index_out,
	output logic                       writeback_valid,
	output logic [bctc_pkg::BLK_W-1:0] writeback_block
);

	bctc_pkg::cmd_t  cmd;
	bctc_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	bctc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .st(st), .cmd(cmd), .busy(busy)
	);

	bctc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.kind(kind), .block_number(block_number), .file_block_count(file_block_count),
		.slot_index(slot_index), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.done(done), .status(status), .slot_index_out(slot_index_out),
		.writeback_valid(writeback_valid), .writeback_block(writeback_block)
	);

endmodule

>>> design/bctc_ctrl.sv
`timescale 1ns / 1ps
module bctc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bctc_pkg::stat_t  st,
	output bctc_pkg::cmd_t   cmd,
	output logic             busy
);

	bctc_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bctc_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bctc_pkg::S_IDLE: begin
				if (start) begin
					if (!st.start_req) state_d = bctc_pkg::S_OPRD;
					else if (st.fill_zero) state_d = bctc_pkg::S_ALLOC;
					else state_d = bctc_pkg::S_HRD;
				end
			end
			bctc_pkg::S_HRD: state_d = bctc_pkg::S_HCMP;
			bctc_pkg::S_HCMP: begin
				if (st.tag_match) state_d = bctc_pkg::S_IDLE;
				else if (st.scan_last) state_d = bctc_pkg::S_ALLOC;
				else state_d = bctc_pkg::S_HRD;
			end
			bctc_pkg::S_ALLOC: state_d = st.fill_full ? bctc_pkg::S_VSCAN : bctc_pkg::S_WBRD;
			bctc_pkg::S_VSCAN: begin
				if (!st.vlocked) state_d = bctc_pkg::S_WBRD;
				else if (st.vlast) state_d = bctc_pkg::S_IDLE;
			end
			bctc_pkg::S_WBRD: state_d = bctc_pkg::S_WB;
			bctc_pkg::S_WB: state_d = bctc_pkg::S_IDLE;
			bctc_pkg::S_OPRD: state_d = bctc_pkg::S_OPDO;
			bctc_pkg::S_OPDO: state_d = bctc_pkg::S_IDLE;
			default: state_d = bctc_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			bctc_pkg::S_IDLE: cmd.load = start;
			bctc_pkg::S_HRD: cmd.rd_hit = 1'b1;
			bctc_pkg::S_HCMP: begin
				cmd.hit  = st.tag_match;
				cmd.step = !st.tag_match && !st.scan_last;
			end
			bctc_pkg::S_ALLOC: cmd.alloc = 1'b1;
			bctc_pkg::S_VSCAN: begin
				cmd.vstep      = !st.vlocked || !st.vlast;
				cmd.all_locked = st.vlocked && st.vlast;
			end
			bctc_pkg::S_WBRD: cmd.rd_slot = 1'b1;
			bctc_pkg::S_WB: cmd.commit = 1'b1;
			bctc_pkg::S_OPRD: cmd.op_rd = 1'b1;
			bctc_pkg::S_OPDO: cmd.op_do = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != bctc_pkg::S_IDLE);

endmodule

>>> design/bctc_dp.sv
`timescale 1ns / 1ps
module bctc_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bctc_pkg::cmd_t             cmd,
	output bctc_pkg::stat_t            st,
	input  logic [2:0]                 kind,
	input  logic [bctc_pkg::BLK_W-1:0] block_number,
	input  logic [bctc_pkg::BLK_W-1:0] file_block_count,
	input  logic [7:0]                 slot_index,
	input  logic                       cfg_valid,
	input  logic                       cfg_data,
	output logic                       done,
	output logic [2:0]                 status,
	output logic [7:0]                 slot_index_out,
	output logic                       writeback_valid,
	output logic [bctc_pkg::BLK_W-1:0] writeback_block
);

	localparam int N  = bctc_pkg::NUM_SLOTS;
	localparam int SW = bctc_pkg::SLOT_W;
	localparam int CW = bctc_pkg::CNT_W;
	localparam int BW = bctc_pkg::BLK_W;

	logic [BW-1:0] tag_mem [N];
	logic [BW-1:0] rdata_q;
	logic [SW-1:0] rd_addr;
	logic [2:0]    kind_q;
	logic [BW-1:0] blk_q, flen_q;
	logic [7:0]    si_q;
	logic [SW-1:0] idx_q, slot_q, c_q, vcnt_q, vp_q;
	logic [CW-1:0] fill_q;
	logic [N-1:0]  dirty_q, lock_q;
	logic          ro_q;
	logic [SW-1:0] sidx, c_next;
	logic          in_rng, kind_ok;

	// tag memory, one port, registered read
	always_comb begin
		rd_addr = idx_q;
		if (cmd.rd_slot) rd_addr = slot_q;
		else if (cmd.op_rd) rd_addr = sidx;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_hit || cmd.rd_slot || cmd.op_rd) rdata_q <= tag_mem[rd_addr];
		if (cmd.commit) tag_mem[slot_q] <= blk_q;
	end

	assign sidx    = SW'(si_q);
	assign in_rng  = 32'(si_q) < 32'(fill_q);
	assign kind_ok = (kind_q == bctc_pkg::K_DIRTY) || (kind_q == bctc_pkg::K_LOCK) ||
	                 (kind_q == bctc_pkg::K_UNLOCK) || (kind_q == bctc_pkg::K_FLUSH);
	assign c_next  = (32'(c_q) == N - 1) ? '0 : c_q + 1'b1;

	// status to controller
	always_comb begin
		st.start_req = (kind == bctc_pkg::K_REQ);
		st.fill_zero = (fill_q == '0);
		st.tag_match = (rdata_q == blk_q);
		st.scan_last = ((CW'(idx_q) + 1'b1) == fill_q);
		st.fill_full = (32'(fill_q) == N);
		st.vlocked   = lock_q[c_q];
		st.vlast     = (32'(vcnt_q) == N - 1);
	end

	// item payload latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			blk_q  <= block_number;
			flen_q <= file_block_count;
			si_q   <= slot_index;
		end
	end

	// scan counters
	always_ff @(posedge clk) begin
		if (cmd.load) idx_q <= '0;
		else if (cmd.step) idx_q <= idx_q + 1'b1;
		if (cmd.alloc) begin
			c_q    <= vp_q;
			vcnt_q <= '0;
			if (!st.fill_full) slot_q <= SW'(fill_q);
		end else if (cmd.vstep) begin
			if (!st.vlocked) slot_q <= c_q;
			c_q    <= c_next;
			vcnt_q <= vcnt_q + 1'b1;
		end
	end

	// control state: fill count, pointer, dirty and lock bits, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			vp_q    <= '0;
			dirty_q <= '0;
			lock_q  <= '0;
			ro_q    <= 1'b0;
		end else begin
			if (cfg_valid) ro_q <= cfg_data;
			if (cmd.alloc && !st.fill_full) fill_q <= fill_q + 1'b1;
			if (cmd.vstep && !st.vlocked) vp_q <= c_next;
			if (cmd.commit) dirty_q[slot_q] <= 1'b0;
			if (cmd.op_do && kind_ok && in_rng) begin
				case (kind_q)
					bctc_pkg::K_DIRTY:  dirty_q[sidx] <= 1'b1;
					bctc_pkg::K_LOCK:   lock_q[sidx] <= 1'b1;
					bctc_pkg::K_UNLOCK: lock_q[sidx] <= 1'b0;
					bctc_pkg::K_FLUSH:  if (!ro_q) dirty_q[sidx] <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.hit || cmd.commit || cmd.all_locked || cmd.op_do;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.hit) begin
			status          <= bctc_pkg::ST_HIT;
			slot_index_out  <= 8'(idx_q);
			writeback_valid <= 1'b0;
			writeback_block <= '0;
		end else if (cmd.commit) begin
			status          <= (blk_q >= flen_q) ? bctc_pkg::ST_APPEND : bctc_pkg::ST_LOAD;
			slot_index_out  <= 8'(slot_q);
			writeback_valid <= dirty_q[slot_q];
			writeback_block <= dirty_q[slot_q] ? rdata_q : '0;
		end else if (cmd.all_locked) begin
			status          <= bctc_pkg::ST_LOCKED;
			slot_index_out  <= '0;
			writeback_valid <= 1'b0;
			writeback_block <= '0;
		end else if (cmd.op_do) begin
			status          <= bctc_pkg::ST_DONE;
			slot_index_out  <= si_q;
			if (kind_q == bctc_pkg::K_FLUSH && in_rng && !ro_q && dirty_q[sidx]) begin
				writeback_valid <= 1'b1;
				writeback_block <= rdata_q;
			end else begin
				writeback_valid <= 1'b0;
				writeback_block <= '0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) 32'(fill_q) <= N)
		else $error("fill count beyond slot count");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held two cycles");
	a_hit_no_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bctc_pkg::ST_HIT) |-> !writeback_valid)
		else $error("hit reported a writeback");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

// Tracks the tag file, dirty/lock bits and victim pointer; queues the expected outcome
class tag_scoreboard;
	typedef struct {
		logic [2:0]                 st;
		logic [7:0]                 slot;
		logic                       wv;
		logic [bctc_pkg::BLK_W-1:0] wb;
	} outcome_t;

	outcome_t                   want_q[$];
	logic [bctc_pkg::BLK_W-1:0] tags [bctc_pkg::NUM_SLOTS];
	bit                         dirty [bctc_pkg::NUM_SLOTS];
	bit                         locked [bctc_pkg::NUM_SLOTS];
	int                         fill;
	int                         vptr;
	bit                         read_only;
	int                         errors, n_items, n_hits, n_wb, n_all_locked, n_append;

	function void clear();
		fill = 0;
		vptr = 0;
		read_only = 0;
		foreach (dirty[i]) begin
			dirty[i] = 0;
			locked[i] = 0;
		end
	endfunction

	function int pending();
		return want_q.size();
	endfunction

	// accepted item: update the tag state and queue the outcome it must produce
	function void note_item(logic [2:0] k, logic [bctc_pkg::BLK_W-1:0] blk,
			logic [bctc_pkg::BLK_W-1:0] flen, logic [7:0] si);
		outcome_t o;
		int       slot;
		bit       found;
		o = '{bctc_pkg::ST_DONE, si, 1'b0, '0};
		n_items++;
		if (k == bctc_pkg::K_REQ) begin
			found = 0;
			for (int i = 0; i < fill; i++) begin
				if (!found && tags[i] == blk) begin
					found = 1;
					o = '{bctc_pkg::ST_HIT, i[7:0], 1'b0, '0};
				end
			end
			if (found) begin
				n_hits++;
			end else begin
				slot = -1;
				if (fill < bctc_pkg::NUM_SLOTS) begin
					slot = fill;
					fill++;
				end else begin
					for (int i = 0; i < bctc_pkg::NUM_SLOTS; i++) begin
						if (slot < 0 && !locked[(vptr + i) % bctc_pkg::NUM_SLOTS])
							slot = (vptr + i) % bctc_pkg::NUM_SLOTS;
					end
					if (slot >= 0)
						vptr = (slot + 1) % bctc_pkg::NUM_SLOTS;
				end
				if (slot < 0) begin
					o = '{bctc_pkg::ST_LOCKED, 8'd0, 1'b0, '0};
					n_all_locked++;
				end else begin
					o.slot = slot[7:0];
					o.st = (blk >= flen) ? bctc_pkg::ST_APPEND : bctc_pkg::ST_LOAD;
					if (blk >= flen)
						n_append++;
					if (dirty[slot]) begin
						o.wv = 1;
						o.wb = tags[slot];
						n_wb++;
					end
					tags[slot] = blk;
					dirty[slot] = 0;
				end
			end
		end else if (k <= bctc_pkg::K_FLUSH && si < fill) begin
			case (k)
				bctc_pkg::K_DIRTY:  dirty[si] = 1;
				bctc_pkg::K_LOCK:   locked[si] = 1;
				bctc_pkg::K_UNLOCK: locked[si] = 0;
				default: begin
					if (!read_only && dirty[si]) begin
						dirty[si] = 0;
						o.wv = 1;
						o.wb = tags[si];
						n_wb++;
					end
				end
			endcase
		end
		want_q.push_back(o);
	endfunction

	function void check_result(logic [2:0] st, logic [7:0] slot, logic wv,
			logic [bctc_pkg::BLK_W-1:0] wb);
		outcome_t o;
		if (want_q.size() == 0) begin
			$error("result with nothing expected: status %0d slot %0d", st, slot);
			errors++;
			return;
		end
		o = want_q.pop_front();
		if (st !== o.st) begin
			$error("status: expected %0d, got %0d", o.st, st);
			errors++;
		end
		if (slot !== o.slot) begin
			$error("slot_index_out: expected %0d, got %0d", o.slot, slot);
			errors++;
		end
		if (wv !== o.wv) begin
			$error("writeback_valid: expected %0d, got %0d", o.wv, wv);
			errors++;
		end
		if (wb !== o.wb) begin
			$error("writeback_block: expected %h, got %h", o.wb, wb);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int POOL_N      = 320;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       start = 0;
	logic                       busy;
	logic [2:0]                 kind = '0;
	logic [bctc_pkg::BLK_W-1:0] block_number = '0;
	logic [bctc_pkg::BLK_W-1:0] file_block_count = '0;
	logic [7:0]                 slot_index = '0;
	logic                       cfg_valid = 0;
	logic                       cfg_ready;
	logic                       cfg_data = 0;
	logic                       done;
	logic [2:0]                 status;
	logic [7:0]                 slot_index_out;
	logic                       writeback_valid;
	logic [bctc_pkg::BLK_W-1:0] writeback_block;

	tag_scoreboard              tags_sb = new();
	logic [bctc_pkg::BLK_W-1:0] blk_pool [POOL_N];
	int                         burst_left = 0;
	int                         cycles = 0;

	block_cache_tag_controller dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .kind(kind),
		.block_number(block_number), .file_block_count(file_block_count),
		.slot_index(slot_index), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .done(done), .status(status),
		.slot_index_out(slot_index_out), .writeback_valid(writeback_valid),
		.writeback_block(writeback_block)
	);

	always #1 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result monitor: every strobed result is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done)
			tags_sb.check_result(status, slot_index_out, writeback_valid, writeback_block);
	end

	function automatic logic [bctc_pkg::BLK_W-1:0] rand_blk();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[bctc_pkg::BLK_W-1:0];
	endfunction

	// one item: random gaps between bursts, then hold start until the block takes it
	task automatic send_item(logic [2:0] k, logic [bctc_pkg::BLK_W-1:0] blk,
			logic [bctc_pkg::BLK_W-1:0] flen, logic [7:0] si);
		if (burst_left == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		kind <= k;
		block_number <= blk;
		file_block_count <= flen;
		slot_index <= si;
		start <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);
		tags_sb.note_item(k, blk, flen, si);
	endtask

	task automatic drain();
		start <= 0;
		burst_left = 0;
		while (tags_sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_read_only(logic v);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tags_sb.read_only = v;
		cfg_valid <= 0;
	endtask

	function automatic logic [7:0] pick_slot();
		if (tags_sb.fill > 0 && $urandom_range(0, 9) != 0)
			return 8'($urandom_range(0, tags_sb.fill - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	// a request drawn mostly from the pool so that hits and evictions both happen
	task automatic send_request();
		logic [bctc_pkg::BLK_W-1:0] blk, flen;
		blk = ($urandom_range(0, 19) == 0) ? rand_blk() : blk_pool[$urandom_range(0, POOL_N - 1)];
		case ($urandom_range(0, 3))
			0: flen = blk;
			1: flen = blk + 63'd1;
			default: flen = rand_blk();
		endcase
		send_item(bctc_pkg::K_REQ, blk, flen, 8'($urandom_range(0, 255)));
	endtask

	task automatic random_items(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 60)
				send_request();
			else if (r < 72)
				send_item(bctc_pkg::K_DIRTY, rand_blk(), rand_blk(), pick_slot());
			else if (r < 80)
				send_item(bctc_pkg::K_LOCK, rand_blk(), rand_blk(), pick_slot());
			else if (r < 88)
				send_item(bctc_pkg::K_UNLOCK, rand_blk(), rand_blk(), pick_slot());
			else if (r < 96)
				send_item(bctc_pkg::K_FLUSH, rand_blk(), rand_blk(), pick_slot());
			else
				send_item(3'($urandom_range(5, 7)), rand_blk(), rand_blk(),
					8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		tags_sb.clear();
		foreach (blk_pool[i])
			blk_pool[i] = rand_blk();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_read_only(0);

		// directed: field extremes, each kind, unfilled slot, unknown kinds
		send_item(bctc_pkg::K_FLUSH, '0, '0, 8'd0);
		send_item(bctc_pkg::K_REQ, '0, '0, 8'd0);
		send_item(bctc_pkg::K_REQ, {bctc_pkg::BLK_W{1'b1}}, '0, 8'd255);
		send_item(bctc_pkg::K_REQ, 63'd5, {bctc_pkg::BLK_W{1'b1}}, 8'd0);
		send_item(bctc_pkg::K_REQ, {bctc_pkg::BLK_W{1'b1}}, {bctc_pkg::BLK_W{1'b1}}, 8'd0);
		send_item(bctc_pkg::K_DIRTY, '0, '0, 8'd1);
		send_item(bctc_pkg::K_FLUSH, '0, '0, 8'd1);
		send_item(bctc_pkg::K_FLUSH, '0, '0, 8'd1);
		send_item(bctc_pkg::K_LOCK, '0, '0, 8'd2);
		send_item(bctc_pkg::K_UNLOCK, '0, '0, 8'd2);
		send_item(bctc_pkg::K_DIRTY, '0, '0, 8'd0);
		send_item(bctc_pkg::K_REQ, '0, 63'd7, 8'd0);
		send_item(bctc_pkg::K_LOCK, '0, '0, 8'd200);
		send_item(bctc_pkg::K_DIRTY, '0, '0, 8'd255);
		send_item(3'd5, '0, '0, 8'd255);
		send_item(3'd6, {bctc_pkg::BLK_W{1'b1}}, {bctc_pkg::BLK_W{1'b1}}, 8'd17);
		send_item(3'd7, '0, '0, 8'd0);
		drain();

		// random phases across both settings of the register
		for (int p = 0; p < 4; p++) begin
			write_read_only(p[0]);
			random_items(p == 2 ? 180 : 330);
			if (p == 2) begin
				// fill up, lock every slot, then miss and hit under a fully locked file
				while (tags_sb.fill < bctc_pkg::NUM_SLOTS)
					send_item(bctc_pkg::K_REQ, rand_blk(), rand_blk(), 8'd0);
				for (int s = 0; s < bctc_pkg::NUM_SLOTS; s++)
					send_item(bctc_pkg::K_LOCK, '0, '0, s[7:0]);
				send_item(bctc_pkg::K_REQ, rand_blk(), rand_blk(), 8'd0);
				send_item(bctc_pkg::K_REQ, tags_sb.tags[9], '0, 8'd0);
				for (int s = 0; s < bctc_pkg::NUM_SLOTS; s++)
					send_item(bctc_pkg::K_UNLOCK, '0, '0, s[7:0]);
			end
			drain();
		end

		$display("covered %0d items: %0d hits, %0d appends, %0d writebacks, %0d all-locked",
			tags_sb.n_items, tags_sb.n_hits, tags_sb.n_append, tags_sb.n_wb,
			tags_sb.n_all_locked);
		if (tags_sb.errors == 0 && tags_sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
